### sv/srms_pkg.sv
// shared types, constants and opcodes of the six register machine step block
package srms_pkg;

  localparam int unsigned REG_COUNT = 6;
  localparam int unsigned IDX_W     = $clog2(REG_COUNT);
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned IMM_W     = 32;
  localparam int unsigned LEN_W     = 17;
  localparam int unsigned PTR_W     = 3;
  localparam int unsigned DST_W     = 3;
  localparam int unsigned OP_W      = 4;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [REG_COUNT-1:0] rf_t;

  // instruction set
  typedef enum logic [OP_W-1:0] {
    OP_ADDR = 4'd0,
    OP_ADDI = 4'd1,
    OP_MULR = 4'd2,
    OP_MULI = 4'd3,
    OP_BANR = 4'd4,
    OP_BANI = 4'd5,
    OP_BORR = 4'd6,
    OP_BORI = 4'd7,
    OP_SETR = 4'd8,
    OP_SETI = 4'd9,
    OP_GTIR = 4'd10,
    OP_GTRI = 4'd11,
    OP_GTRR = 4'd12,
    OP_EQIR = 4'd13,
    OP_EQRI = 4'd14,
    OP_EQRR = 4'd15
  } op_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_POINTER = 1'b0,
    CFG_LENGTH  = 1'b1
  } cfg_idx_t;

  // register file update for one executed instruction
  typedef struct packed {
    logic            en;
    logic            wr_en;
    logic [DST_W-1:0] wr_idx;
    word_t           wr_val;
  } commit_t;

endpackage

### sv/srms_regfile.sv
// register file with the instruction pointer copy folded into its read view
module srms_regfile (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [srms_pkg::PTR_W-1:0] ptr,
  input  srms_pkg::word_t            pc,
  input  srms_pkg::commit_t          commit,
  output srms_pkg::rf_t              view
);

  srms_pkg::rf_t regs;
  srms_pkg::rf_t regs_next;

  // view seen by the instruction: bound pointer register holds the counter
  always_comb begin
    for (int k = 0; k < srms_pkg::REG_COUNT; k++) begin
      if (ptr == srms_pkg::PTR_W'(k)) begin
        view[k] = pc;
      end else begin
        view[k] = regs[k];
      end
    end
  end

  // destination write wins over the pointer copy
  always_comb begin
    for (int k = 0; k < srms_pkg::REG_COUNT; k++) begin
      if (commit.wr_en && commit.wr_idx == srms_pkg::DST_W'(k)) begin
        regs_next[k] = commit.wr_val;
      end else begin
        regs_next[k] = view[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (commit.en) begin
      regs <= regs_next;
    end
  end

endmodule

### sv/srms_alu.sv
// operand fetch, index check and the sixteen operations of one instruction
module srms_alu (
  input  srms_pkg::rf_t              view,
  input  srms_pkg::op_t              op,
  input  logic [srms_pkg::IMM_W-1:0] opa,
  input  logic [srms_pkg::IMM_W-1:0] opb,
  input  logic [srms_pkg::DST_W-1:0] dst,
  output srms_pkg::word_t            value,
  output logic                       bad
);

  logic            ra_ok, rb_ok, dst_ok;
  logic            uses_ra, uses_rb;
  srms_pkg::word_t ra, rb, ia, ib;
  srms_pkg::word_t mul_y, raw;
  logic [63:0]     pp_ll;
  logic [31:0]     pp_lh, pp_hl;
  srms_pkg::word_t prod;

  // immediates are sign extended
  assign ia = {{(srms_pkg::WORD_W-srms_pkg::IMM_W){opa[srms_pkg::IMM_W-1]}}, opa};
  assign ib = {{(srms_pkg::WORD_W-srms_pkg::IMM_W){opb[srms_pkg::IMM_W-1]}}, opb};

  // register reads; negative or large indexes are out of range
  assign ra_ok  = opa < srms_pkg::IMM_W'(srms_pkg::REG_COUNT);
  assign rb_ok  = opb < srms_pkg::IMM_W'(srms_pkg::REG_COUNT);
  assign dst_ok = dst < srms_pkg::DST_W'(srms_pkg::REG_COUNT);
  assign ra     = ra_ok ? view[opa[srms_pkg::IDX_W-1:0]] : '0;
  assign rb     = rb_ok ? view[opb[srms_pkg::IDX_W-1:0]] : '0;

  // which operands are register references
  always_comb begin
    case (op)
      srms_pkg::OP_ADDR, srms_pkg::OP_MULR, srms_pkg::OP_BANR, srms_pkg::OP_BORR,
      srms_pkg::OP_GTRR, srms_pkg::OP_EQRR: begin
        uses_ra = 1'b1;
        uses_rb = 1'b1;
      end
      srms_pkg::OP_ADDI, srms_pkg::OP_MULI, srms_pkg::OP_BANI, srms_pkg::OP_BORI,
      srms_pkg::OP_SETR, srms_pkg::OP_GTRI, srms_pkg::OP_EQRI: begin
        uses_ra = 1'b1;
        uses_rb = 1'b0;
      end
      srms_pkg::OP_GTIR, srms_pkg::OP_EQIR: begin
        uses_ra = 1'b0;
        uses_rb = 1'b1;
      end
      default: begin
        uses_ra = 1'b0;
        uses_rb = 1'b0;
      end
    endcase
  end

  // low 64 bits of the product from three 32x32 partial products
  assign mul_y = (op == srms_pkg::OP_MULR) ? rb : ib;
  assign pp_ll = ra[31:0] * mul_y[31:0];
  assign pp_lh = 32'(ra[31:0] * mul_y[63:32]);
  assign pp_hl = 32'(ra[63:32] * mul_y[31:0]);
  assign prod  = pp_ll + {pp_lh + pp_hl, 32'd0};

  // operation select
  always_comb begin
    case (op)
      srms_pkg::OP_ADDR: raw = ra + rb;
      srms_pkg::OP_ADDI: raw = ra + ib;
      srms_pkg::OP_MULR: raw = prod;
      srms_pkg::OP_MULI: raw = prod;
      srms_pkg::OP_BANR: raw = ra & rb;
      srms_pkg::OP_BANI: raw = ra & ib;
      srms_pkg::OP_BORR: raw = ra | rb;
      srms_pkg::OP_BORI: raw = ra | ib;
      srms_pkg::OP_SETR: raw = ra;
      srms_pkg::OP_SETI: raw = ia;
      srms_pkg::OP_GTIR: raw = srms_pkg::WORD_W'($signed(ia) > $signed(rb));
      srms_pkg::OP_GTRI: raw = srms_pkg::WORD_W'($signed(ra) > $signed(ib));
      srms_pkg::OP_GTRR: raw = srms_pkg::WORD_W'($signed(ra) > $signed(rb));
      srms_pkg::OP_EQIR: raw = srms_pkg::WORD_W'(ia == rb);
      srms_pkg::OP_EQRI: raw = srms_pkg::WORD_W'(ra == ib);
      srms_pkg::OP_EQRR: raw = srms_pkg::WORD_W'(ra == rb);
      default:           raw = '0;
    endcase
  end

  // a bad index suppresses the write and zeroes the value
  assign bad   = (uses_ra && !ra_ok) || (uses_rb && !rb_ok) || !dst_ok;
  assign value = bad ? '0 : raw;

endmodule

### sv/six_register_machine_step.sv
// Six register machine step: executes one instruction per request.
// Input channel (in_valid/in_ready) carries operation, operand_a, operand_b
// and dest_index. Output channel (out_valid/out_ready) returns next_counter,
// written_value, written_index, halted and bad_index, one result per request.
// Before the instruction runs the program counter is copied into the register
// selected by pointer_register; the next counter is that register plus one.
// An APB port sets pointer_register (address 0) and program_length
// (address 4); write it only while the block is idle.
// A request accepted into the input register is executed from there, and its
// result is captured in the result register, which drives the output channel.
// Throughput: one request per cycle while out_ready is high; the execute loop
// through the register file and the 64-bit ALU (three 32x32 partial products) sets it.
// When the receiver stalls the result register holds, the input register
// fills with one more request, and then in_ready drops until out_ready.
// Reset clears all six registers and the program counter, sets the pointer
// register to 0 and the program length to 1, and empties both stages.
module six_register_machine_step (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [srms_pkg::OP_W-1:0]     operation,
  input  logic signed [srms_pkg::IMM_W-1:0] operand_a,
  input  logic signed [srms_pkg::IMM_W-1:0] operand_b,
  input  logic [srms_pkg::DST_W-1:0]    dest_index,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [srms_pkg::WORD_W-1:0] next_counter,
  output logic signed [srms_pkg::WORD_W-1:0] written_value,
  output logic [srms_pkg::DST_W-1:0]    written_index,
  output logic                          halted,
  output logic                          bad_index,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srms_pkg::ADDR_W-1:0]   paddr,
  input  logic [srms_pkg::DATA_W-1:0]   pwdata,
  output logic [srms_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  // configuration registers
  logic [srms_pkg::PTR_W-1:0] pointer_register;
  logic [srms_pkg::LEN_W-1:0] program_length;
  logic                       cfg_wr;
  srms_pkg::cfg_idx_t         cfg_idx;

  // input register
  logic                       item_valid;
  srms_pkg::op_t              op_q;
  logic [srms_pkg::IMM_W-1:0] opa_q, opb_q;
  logic [srms_pkg::DST_W-1:0] dst_q;

  // execute
  logic                       exec_fire;
  srms_pkg::word_t            pc;
  srms_pkg::word_t            pc_next;
  srms_pkg::word_t            ptr_final;
  srms_pkg::rf_t              view;
  srms_pkg::word_t            value;
  logic                       bad;
  logic                       bound;
  logic                       halt_next;
  srms_pkg::commit_t          commit;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = srms_pkg::cfg_idx_t'(paddr[2]);

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      pointer_register <= '0;
      program_length   <= srms_pkg::LEN_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        srms_pkg::CFG_POINTER: pointer_register <= pwdata[srms_pkg::PTR_W-1:0];
        srms_pkg::CFG_LENGTH:  program_length   <= pwdata[srms_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // configuration read
  always_comb begin
    unique case (cfg_idx)
      srms_pkg::CFG_POINTER: prdata = srms_pkg::DATA_W'(pointer_register);
      srms_pkg::CFG_LENGTH:  prdata = srms_pkg::DATA_W'(program_length);
      default:               prdata = '0;
    endcase
  end

  // handshake: execute when the result register is free or being drained
  assign exec_fire = item_valid && (!out_valid || out_ready);
  assign in_ready  = !item_valid || exec_fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_q  <= srms_pkg::op_t'(operation);
      opa_q <= operand_a;
      opb_q <= operand_b;
      dst_q <= dest_index;
    end
  end

  srms_regfile u_regfile (
    .clk    (clk),
    .rst    (rst),
    .ptr    (pointer_register),
    .pc     (pc),
    .commit (commit),
    .view   (view)
  );

  srms_alu u_alu (
    .view  (view),
    .op    (op_q),
    .opa   (opa_q),
    .opb   (opb_q),
    .dst   (dst_q),
    .value (value),
    .bad   (bad)
  );

  assign commit.en     = exec_fire;
  assign commit.wr_en  = !bad;
  assign commit.wr_idx = dst_q;
  assign commit.wr_val = value;

  // next counter from the pointer register after the write
  assign bound     = pointer_register < srms_pkg::PTR_W'(srms_pkg::REG_COUNT);
  assign ptr_final = (!bad && dst_q == srms_pkg::DST_W'(pointer_register)) ? value : pc;
  assign pc_next   = (bound ? ptr_final : pc) + srms_pkg::WORD_W'(1);
  assign halt_next = pc_next[srms_pkg::WORD_W-1] ||
                     (pc_next >= srms_pkg::WORD_W'(program_length));

  // program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (exec_fire) begin
      pc <= pc_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      next_counter  <= pc_next;
      written_value <= value;
      written_index <= dst_q;
      halted        <= halt_next;
      bad_index     <= bad;
    end
  end

endmodule

### sv/srms_checker.sv
// port level checks of the six register machine step block and their binding
module srms_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [srms_pkg::WORD_W-1:0] next_counter,
  input logic signed [srms_pkg::WORD_W-1:0] written_value,
  input logic [srms_pkg::DST_W-1:0]        written_index,
  input logic                              halted,
  input logic                              bad_index
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_counter) &&
      $stable(written_value) && $stable(halted) && $stable(bad_index))
    else $error("stalled result changed");

  // reset empties the result register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a suppressed write reports a zero value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_index |-> written_value == '0)
    else $error("bad index with nonzero value");

  // a good result names a real register
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_index |-> written_index < srms_pkg::DST_W'(srms_pkg::REG_COUNT))
    else $error("write to a register that does not exist");

  // a negative counter always halts
  assert property (@(posedge clk) disable iff (rst)
    out_valid && next_counter[srms_pkg::WORD_W-1] |-> halted)
    else $error("negative counter not halted");

endmodule

bind six_register_machine_step srms_checker u_srms_checker (.*);
